[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MWE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define MWE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hdl/mwe_pkg.sv]
`timescale 1ns / 1ps

package mwe_pkg;

    localparam int ADDR_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    // command codes on the opcode field
    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_ERASE     = 3'd2;
    localparam logic [2:0] OP_WRITE_ALL = 3'd3;
    localparam logic [2:0] OP_ERASE_ALL = 3'd4;
    localparam logic [2:0] OP_ENABLE    = 3'd5;
    localparam logic [2:0] OP_DISABLE   = 3'd6;

    // 2-bit opcode sent after the start bit
    localparam logic [1:0] FOP_EXT   = 2'b00;
    localparam logic [1:0] FOP_WRITE = 2'b01;
    localparam logic [1:0] FOP_READ  = 2'b10;
    localparam logic [1:0] FOP_ERASE = 2'b11;

    // extended command codes in the top two address positions
    localparam logic [1:0] CODE_EWDS = 2'b00;
    localparam logic [1:0] CODE_WRAL = 2'b01;
    localparam logic [1:0] CODE_ERAL = 2'b10;
    localparam logic [1:0] CODE_EWEN = 2'b11;

    // one period item after classification
    typedef struct packed {
        logic       cmd_ok;
        logic       modifying;
        logic [2:0] opcode;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       serial_data_in;
    } item_t;

endpackage

[hdl/mwe_front.sv]
`timescale 1ns / 1ps

module mwe_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                command_valid,
    input  logic [2:0]          opcode,
    input  logic [7:0]          address,
    input  logic [7:0]          write_data,
    input  logic                serial_data_in,
    output logic                push,
    input  logic                queue_full,
    output mwe_pkg::item_t      push_item
);

    logic           fr_valid_reg;
    logic           fr_valid_next;
    mwe_pkg::item_t fr_item_reg;
    mwe_pkg::item_t fr_item_next;
    logic           accept;

    assign item_stall = fr_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign push       = fr_valid_reg && !queue_full;
    assign push_item  = fr_item_reg;

    always_comb
    begin
        fr_item_next.cmd_ok         = command_valid && (opcode <= mwe_pkg::OP_DISABLE);
        fr_item_next.modifying      = (opcode >= mwe_pkg::OP_WRITE)
                                   && (opcode <= mwe_pkg::OP_ERASE_ALL);
        fr_item_next.opcode         = opcode;
        fr_item_next.address        = address;
        fr_item_next.write_data     = write_data;
        fr_item_next.serial_data_in = serial_data_in;
    end

    always_comb
    begin
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else
        begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_item_reg <= fr_item_next;
        end
    end

endmodule

[hdl/mwe_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwe_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mwe_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mwe_pkg::item_t head_item
);

    localparam int PTR_W = (mwe_pkg::QUEUE_DEPTH > 1) ? $clog2(mwe_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mwe_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mwe_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mwe_pkg::QUEUE_DEPTH);

    mwe_pkg::item_t   mem_reg [mwe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `MWE_ASSERT_NEVER(a_q_no_overflow, clk, rst_n, push && full && !pop, "queue overflow")
    `MWE_ASSERT_NEVER(a_q_no_underflow, clk, rst_n, pop && !head_valid, "queue underflow")
    `MWE_ASSERT(a_q_ptr_match, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with pointers apart")

endmodule

[hdl/mwe_seq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwe_seq
#(
    parameter int ADDR_BITS = mwe_pkg::ADDR_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           head_valid,
    input  mwe_pkg::item_t head_item,
    output logic           pop,
    output logic           result_valid,
    input  logic           result_stall,
    output logic           chip_select,
    output logic           serial_data_out,
    output logic           clock_pulse,
    output logic [7:0]     read_data,
    output logic           done_res,
    output logic           busy_res
);

    localparam int SW    = ADDR_BITS + 11;
    localparam int CNT_W = $clog2(ADDR_BITS + 12);

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b0000000001,
        PH_SEND_EN   = 10'b0000000010,
        PH_GAP_MAIN  = 10'b0000000100,
        PH_SEND_MAIN = 10'b0000001000,
        PH_DUMMY     = 10'b0000010000,
        PH_RECV      = 10'b0000100000,
        PH_GAP_POLL  = 10'b0001000000,
        PH_POLL      = 10'b0010000000,
        PH_GAP_DIS   = 10'b0100000000,
        PH_SEND_DIS  = 10'b1000000000
    } phase_t;

    typedef struct packed {
        logic [SW-1:0]    word;
        logic [CNT_W-1:0] cnt;
    } frame_t;

    function automatic frame_t load_frame(input logic [2:0] op,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic [7:0] data);
        frame_t               f;
        logic [1:0]           opb;
        logic [ADDR_BITS-1:0] field;
        logic                 has_data;
        opb      = mwe_pkg::FOP_EXT;
        field    = '0;
        has_data = 1'b0;
        unique case (op)
            mwe_pkg::OP_READ:
            begin
                opb   = mwe_pkg::FOP_READ;
                field = addr;
            end
            mwe_pkg::OP_WRITE:
            begin
                opb      = mwe_pkg::FOP_WRITE;
                field    = addr;
                has_data = 1'b1;
            end
            mwe_pkg::OP_ERASE:
            begin
                opb   = mwe_pkg::FOP_ERASE;
                field = addr;
            end
            mwe_pkg::OP_WRITE_ALL:
            begin
                field    = {mwe_pkg::CODE_WRAL, {(ADDR_BITS-2){1'b0}}};
                has_data = 1'b1;
            end
            mwe_pkg::OP_ERASE_ALL:
            begin
                field = {mwe_pkg::CODE_ERAL, {(ADDR_BITS-2){1'b0}}};
            end
            mwe_pkg::OP_ENABLE:
            begin
                field = {mwe_pkg::CODE_EWEN, {(ADDR_BITS-2){1'b0}}};
            end
            default:
            begin
                field = {mwe_pkg::CODE_EWDS, {(ADDR_BITS-2){1'b0}}};
            end
        endcase
        if (has_data)
        begin
            f.word = {1'b1, opb, field, data};
            f.cnt  = CNT_W'(ADDR_BITS + 11);
        end
        else
        begin
            f.word = SW'({1'b1, opb, field});
            f.cnt  = CNT_W'(ADDR_BITS + 3);
        end
        return f;
    endfunction

    logic                 auto_reg;
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next, cnt_dec;
    logic [SW-1:0]        shift_reg, shift_next, shift_tap;
    logic [7:0]           rx_reg, rx_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [7:0]           data_reg, data_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 sauto_reg, sauto_next;

    logic                 load;
    logic [2:0]           fr_op;
    logic [ADDR_BITS-1:0] fr_addr;
    logic [7:0]           fr_data;
    frame_t               frm;

    logic                 cs_c, sdo_c, sck_c, done_c, busy_c;
    logic                 out_valid_reg;
    logic                 cs_reg, sdo_reg, sck_reg, done_reg, busy_reg;
    logic [7:0]           rd_reg;
    logic                 step;

    // the sequencer advances one serial period whenever an item waits at the queue head and the output slot frees up
    assign step = head_valid && (!out_valid_reg || !result_stall);
    assign pop  = step;

    assign shift_tap = shift_reg >> (cnt_reg - CNT_W'(1));
    assign cnt_dec   = (cnt_reg != '0) ? cnt_reg - CNT_W'(1) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        addr_next  = addr_reg;
        sauto_next = sauto_reg;
        load       = 1'b0;
        fr_op      = cmd_reg;
        fr_addr    = addr_reg;
        fr_data    = data_reg;
        cs_c       = 1'b0;
        sdo_c      = 1'b0;
        sck_c      = 1'b0;
        done_c     = 1'b0;
        busy_c     = 1'b1;
        unique case (phase_reg) inside
            PH_SEND_EN, PH_SEND_MAIN, PH_SEND_DIS:
            begin
                cs_c     = 1'b1;
                sck_c    = 1'b1;
                sdo_c    = (cnt_reg != '0) ? shift_tap[0] : 1'b0;
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    if (phase_reg == PH_SEND_EN)
                    begin
                        phase_next = PH_GAP_MAIN;
                    end
                    else if (phase_reg == PH_SEND_DIS)
                    begin
                        done_c     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (cmd_reg == mwe_pkg::OP_READ)
                    begin
                        phase_next = PH_DUMMY;
                    end
                    else if ((cmd_reg >= mwe_pkg::OP_WRITE) && (cmd_reg <= mwe_pkg::OP_ERASE_ALL))
                    begin
                        phase_next = PH_GAP_POLL;
                    end
                    else
                    begin
                        done_c     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_GAP_MAIN:
            begin
                load       = 1'b1;
                phase_next = PH_SEND_MAIN;
            end
            PH_DUMMY:
            begin
                cs_c       = 1'b1;
                sck_c      = 1'b1;
                cnt_next   = CNT_W'(8);
                phase_next = PH_RECV;
            end
            PH_RECV:
            begin
                cs_c     = 1'b1;
                sck_c    = 1'b1;
                rx_next  = {rx_reg[6:0], head_item.serial_data_in};
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    done_c     = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_GAP_POLL:
            begin
                phase_next = PH_POLL;
            end
            PH_POLL:
            begin
                cs_c = 1'b1;
                // ready line high ends the internal write cycle
                if (head_item.serial_data_in)
                begin
                    if (sauto_reg)
                    begin
                        phase_next = PH_GAP_DIS;
                    end
                    else
                    begin
                        done_c     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_GAP_DIS:
            begin
                load       = 1'b1;
                fr_op      = mwe_pkg::OP_DISABLE;
                phase_next = PH_SEND_DIS;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (head_item.cmd_ok)
                begin
                    cmd_next   = head_item.opcode;
                    addr_next  = ADDR_BITS'(head_item.address);
                    data_next  = head_item.write_data;
                    sauto_next = auto_reg;
                    load       = 1'b1;
                    fr_addr    = ADDR_BITS'(head_item.address);
                    fr_data    = head_item.write_data;
                    if (head_item.modifying && auto_reg)
                    begin
                        fr_op      = mwe_pkg::OP_ENABLE;
                        phase_next = PH_SEND_EN;
                    end
                    else
                    begin
                        fr_op      = head_item.opcode;
                        phase_next = PH_SEND_MAIN;
                    end
                end
                else
                begin
                    busy_c = 1'b0;
                end
            end
        endcase
        frm = load_frame(fr_op, fr_addr, fr_data);
        if (load)
        begin
            shift_next = frm.word;
            cnt_next   = frm.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg      <= 1'b1;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            rx_reg        <= '0;
            cmd_reg       <= '0;
            data_reg      <= '0;
            addr_reg      <= '0;
            sauto_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                auto_reg <= cfg_wdata;
            end
            if (step)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                shift_reg <= shift_next;
                rx_reg    <= rx_next;
                cmd_reg   <= cmd_next;
                data_reg  <= data_next;
                addr_reg  <= addr_next;
                sauto_reg <= sauto_next;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cs_reg   <= cs_c;
            sdo_reg  <= sdo_c;
            sck_reg  <= sck_c;
            rd_reg   <= rx_next;
            done_reg <= done_c;
            busy_reg <= busy_c;
        end
    end

    assign result_valid    = out_valid_reg;
    assign chip_select     = cs_reg;
    assign serial_data_out = sdo_reg;
    assign clock_pulse     = sck_reg;
    assign read_data       = rd_reg;
    assign done_res        = done_reg;
    assign busy_res        = busy_reg;

    `MWE_ASSERT(a_seq_done_busy, clk, rst_n, (out_valid_reg && done_reg) |-> busy_reg, "done without busy")
    `MWE_ASSERT(a_seq_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(ADDR_BITS + 11), "bit counter out of range")
    `MWE_ASSERT(a_seq_poll_hold, clk, rst_n, (step && (phase_reg == PH_POLL) && !head_item.serial_data_in) |=> (phase_reg == PH_POLL), "poll left while device busy")

endmodule

[hdl/microwire_eeprom_master.sv]
`timescale 1ns / 1ps

// Microwire 93Cxx EEPROM master. Each item is one serial bit period: it carries
// an optional command plus the level sampled on the EEPROM data output, and
// returns one item with the chip select, data out and clock pulse levels for
// that period, the last read byte, and done/busy flags. One item is taken per
// clock while neither side stalls; the bit sequencer in the back end advances one
// period per clock under the same condition, and an item's result passes through
// the input register, the two-entry queue and the output register. Either side
// may stall on its own. Write and erase commands poll the ready line with no
// timeout, and with auto_write_enable set they are wrapped in EWEN and EWDS
// frames.
module microwire_eeprom_master
#(
    parameter int ADDR_BITS = mwe_pkg::ADDR_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       command_valid,
    input  logic [2:0] opcode,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    input  logic       serial_data_in,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       chip_select,
    output logic       serial_data_out,
    output logic       clock_pulse,
    output logic [7:0] read_data,
    output logic       done_res,
    output logic       busy_res
);

    logic           push;
    logic           queue_full;
    mwe_pkg::item_t push_item;
    logic           head_valid;
    mwe_pkg::item_t head_item;
    logic           pop;

    mwe_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command_valid  (command_valid),
        .opcode         (opcode),
        .address        (address),
        .write_data     (write_data),
        .serial_data_in (serial_data_in),
        .push           (push),
        .queue_full     (queue_full),
        .push_item      (push_item)
    );

    mwe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mwe_seq #(
        .ADDR_BITS (ADDR_BITS)
    ) u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .chip_select     (chip_select),
        .serial_data_out (serial_data_out),
        .clock_pulse     (clock_pulse),
        .read_data       (read_data),
        .done_res        (done_res),
        .busy_res        (busy_res)
    );

endmodule

[sim/tb_microwire_eeprom_master.sv]
`timescale 1ns / 1ps

module tb_microwire_eeprom_master;
    import mwe_pkg::*;

    localparam int AW          = ADDR_BITS_DEF;
    localparam int FW          = AW + 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 100;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [1:0] RX_ZEROS  = 2'd0;
    localparam logic [1:0] RX_ONES   = 2'd1;
    localparam logic [1:0] RX_RANDOM = 2'd2;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_SEND_EN, SEQ_GAP_MAIN, SEQ_SEND_MAIN, SEQ_DUMMY,
        SEQ_RECV, SEQ_GAP_POLL, SEQ_POLL, SEQ_GAP_DIS, SEQ_SEND_DIS
    } seq_phase_t;

    typedef struct packed {
        logic       cs;
        logic       sdo;
        logic       sclk;
        logic [7:0] rdata;
        logic       done;
        logic       busy;
    } pin_result_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [2:0]  op;
        logic [7:0]  addr;
        logic [7:0]  wdata;
        logic [1:0]  rx_mode;
        logic [7:0]  poll_wait;
        logic        busy_cmd;
        logic        cfg_mid;
        logic        typed;
        pin_result_t first_pins;
    } cmd_row_t;

    localparam pin_result_t IDLE_RD00 = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam pin_result_t IDLE_RDFF = '{1'b0, 1'b0, 1'b0, 8'hff, 1'b0, 1'b0};
    localparam pin_result_t NO_PINS   = '0;

    // cv op addr data rx poll busy_cmd cfg_mid typed pins
    localparam int N_DIRECTED = 22;
    localparam cmd_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b0, OP_READ,      8'h00, 8'h00, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b1, IDLE_RD00},
        '{1'b1, OP_UNUSED,    8'hff, 8'hff, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b1, IDLE_RD00},
        '{1'b1, OP_READ,      8'hff, 8'h00, RX_ONES,   8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_UNUSED,    8'h00, 8'h00, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b1, IDLE_RDFF},
        '{1'b1, OP_READ,      8'h00, 8'hff, RX_ZEROS,  8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b0, OP_WRITE,     8'h00, 8'h00, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b1, IDLE_RD00},
        '{1'b1, OP_WRITE,     8'h00, 8'hff, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE,     8'hff, 8'h00, RX_RANDOM, 8'd3, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ERASE,     8'haa, 8'h55, RX_RANDOM, 8'd1, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE_ALL, 8'h55, 8'h55, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ERASE_ALL, 8'h33, 8'hcc, RX_RANDOM, 8'd2, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ENABLE,    8'h0f, 8'hf0, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_DISABLE,   8'hf0, 8'h0f, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE,     8'h5a, 8'ha5, RX_RANDOM, 8'd4, 1'b1, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_READ,      8'h3c, 8'hc3, RX_RANDOM, 8'd0, 1'b1, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ERASE,     8'h81, 8'h18, RX_RANDOM, 8'd2, 1'b0, 1'b1, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE,     8'h7e, 8'h81, RX_RANDOM, 8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ERASE_ALL, 8'h00, 8'h00, RX_RANDOM, 8'd5, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE_ALL, 8'h99, 8'haa, RX_RANDOM, 8'd1, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_READ,      8'hc3, 8'h3c, RX_ONES,   8'd0, 1'b0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, OP_ERASE,     8'h01, 8'hfe, RX_RANDOM, 8'd0, 1'b0, 1'b1, 1'b0, NO_PINS},
        '{1'b1, OP_WRITE,     8'h80, 8'h7f, RX_RANDOM, 8'd2, 1'b0, 1'b0, 1'b0, NO_PINS}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       item_valid;
    logic       item_stall;
    logic       command_valid;
    logic [2:0] opcode;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       serial_data_in;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       chip_select;
    logic       serial_data_out;
    logic       clock_pulse;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;

    // sequencer state as the testbench sees it
    seq_phase_t    seq_phase      = SEQ_IDLE;
    logic [4:0]    bits_left      = '0;
    logic [FW-1:0] frame_bits     = '0;
    logic [7:0]    last_read_byte = '0;
    logic [2:0]    held_op        = '0;
    logic [7:0]    held_addr      = '0;
    logic [7:0]    held_data      = '0;
    logic          held_auto      = 1'b0;
    logic          auto_en        = 1'b1;

    pin_result_t pending_pins [$];
    logic        fixed_valid = 1'b0;
    pin_result_t fixed_pins  = '0;

    int unsigned cycle_count   = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned commands_sent = 0;
    int unsigned cfg_writes    = 0;
    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    microwire_eeprom_master #(
        .ADDR_BITS (AW)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .command_valid   (command_valid),
        .opcode          (opcode),
        .address         (address),
        .write_data      (write_data),
        .serial_data_in  (serial_data_in),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .chip_select     (chip_select),
        .serial_data_out (serial_data_out),
        .clock_pulse     (clock_pulse),
        .read_data       (read_data),
        .done_res        (done_res),
        .busy_res        (busy_res)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_pins.size());
        $display("tb_microwire_eeprom_master failed");
        $finish;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic is_modifying(logic [2:0] op);
        return op == OP_WRITE || op == OP_ERASE || op == OP_WRITE_ALL || op == OP_ERASE_ALL;
    endfunction

    function automatic void load_frame(logic [2:0] op);
        logic [1:0]    fop;
        logic [AW-1:0] field;
        logic          with_data;
        fop       = FOP_EXT;
        field     = '0;
        with_data = 1'b0;
        case (op)
            OP_READ:      begin fop = FOP_READ;  field = AW'(held_addr); end
            OP_WRITE:     begin fop = FOP_WRITE; field = AW'(held_addr); with_data = 1'b1; end
            OP_ERASE:     begin fop = FOP_ERASE; field = AW'(held_addr); end
            OP_WRITE_ALL: begin field[AW-1 -: 2] = CODE_WRAL; with_data = 1'b1; end
            OP_ERASE_ALL: field[AW-1 -: 2] = CODE_ERAL;
            OP_ENABLE:    field[AW-1 -: 2] = CODE_EWEN;
            default:      field[AW-1 -: 2] = CODE_EWDS;
        endcase
        if (with_data)
        begin
            frame_bits = {1'b1, fop, field, held_data};
            bits_left  = 5'(AW + 11);
        end
        else
        begin
            frame_bits = FW'({1'b1, fop, field});
            bits_left  = 5'(AW + 3);
        end
    endfunction

    // one serial bit period of the sequencer
    function automatic pin_result_t advance_bit_period(logic cv, logic [2:0] op,
                                                       logic [7:0] addr, logic [7:0] wd,
                                                       logic sdi);
        pin_result_t r;
        r      = '0;
        r.busy = 1'b1;
        case (seq_phase)
            SEQ_SEND_EN, SEQ_SEND_MAIN, SEQ_SEND_DIS:
            begin
                r.cs   = 1'b1;
                r.sclk = 1'b1;
                if (bits_left != 0)
                begin
                    r.sdo     = frame_bits[bits_left - 5'd1];
                    bits_left = bits_left - 5'd1;
                end
                if (bits_left == 0)
                begin
                    if (seq_phase == SEQ_SEND_EN)
                        seq_phase = SEQ_GAP_MAIN;
                    else if (seq_phase == SEQ_SEND_DIS)
                    begin
                        r.done    = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                    else if (held_op == OP_READ)
                        seq_phase = SEQ_DUMMY;
                    else if (is_modifying(held_op))
                        seq_phase = SEQ_GAP_POLL;
                    else
                    begin
                        r.done    = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                end
            end
            SEQ_GAP_MAIN:
            begin
                load_frame(held_op);
                seq_phase = SEQ_SEND_MAIN;
            end
            SEQ_DUMMY:
            begin
                r.cs      = 1'b1;
                r.sclk    = 1'b1;
                bits_left = 5'd8;
                seq_phase = SEQ_RECV;
            end
            SEQ_RECV:
            begin
                r.cs           = 1'b1;
                r.sclk         = 1'b1;
                last_read_byte = {last_read_byte[6:0], sdi};
                if (bits_left != 0)
                    bits_left = bits_left - 5'd1;
                if (bits_left == 0)
                begin
                    r.done    = 1'b1;
                    seq_phase = SEQ_IDLE;
                end
            end
            SEQ_GAP_POLL:
                seq_phase = SEQ_POLL;
            SEQ_POLL:
            begin
                r.cs = 1'b1;
                if (sdi)
                begin
                    if (held_auto)
                        seq_phase = SEQ_GAP_DIS;
                    else
                    begin
                        r.done    = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                end
            end
            SEQ_GAP_DIS:
            begin
                load_frame(OP_DISABLE);
                seq_phase = SEQ_SEND_DIS;
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                if (cv && op != OP_UNUSED)
                begin
                    held_op   = op;
                    held_addr = addr;
                    held_data = wd;
                    held_auto = auto_en;
                    if (is_modifying(op) && held_auto)
                    begin
                        load_frame(OP_ENABLE);
                        seq_phase = SEQ_SEND_EN;
                    end
                    else
                    begin
                        load_frame(op);
                        seq_phase = SEQ_SEND_MAIN;
                    end
                end
                else
                    r.busy = 1'b0;
            end
        endcase
        r.rdata = last_read_byte;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_pins(pin_result_t got, pin_result_t want);
        if (got.cs !== want.cs)
            report_mismatch($sformatf("result %0d chip_select %b, want %b",
                                      results_seen, got.cs, want.cs));
        if (got.sdo !== want.sdo)
            report_mismatch($sformatf("result %0d serial_data_out %b, want %b",
                                      results_seen, got.sdo, want.sdo));
        if (got.sclk !== want.sclk)
            report_mismatch($sformatf("result %0d clock_pulse %b, want %b",
                                      results_seen, got.sclk, want.sclk));
        if (got.rdata !== want.rdata)
            report_mismatch($sformatf("result %0d read_data %h, want %h",
                                      results_seen, got.rdata, want.rdata));
        if (got.done !== want.done)
            report_mismatch($sformatf("result %0d done_res %b, want %b",
                                      results_seen, got.done, want.done));
        if (got.busy !== want.busy)
            report_mismatch($sformatf("result %0d busy_res %b, want %b",
                                      results_seen, got.busy, want.busy));
    endtask

    // both handshakes are observed here, at the rising edge
    always @(posedge clk)
    begin
        pin_result_t want;
        pin_result_t got;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                want = advance_bit_period(command_valid, opcode, address, write_data,
                                          serial_data_in);
                if (fixed_valid)
                    want = fixed_pins;
                pending_pins.push_back(want);
                items_taken++;
            end
            if (result_valid && !result_stall)
            begin
                got = '{chip_select, serial_data_out, clock_pulse, read_data,
                        done_res, busy_res};
                results_seen++;
                if (pending_pins.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing pending",
                                              results_seen));
                else
                    check_pins(got, pending_pins.pop_front());
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(logic cv, logic [2:0] op, logic [7:0] addr, logic [7:0] wd,
                             logic sdi, logic typed, pin_result_t pins);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid     <= 1'b1;
        command_valid  <= cv;
        opcode         <= op;
        address        <= addr;
        write_data     <= wd;
        serial_data_in <= sdi;
        fixed_valid    = typed;
        fixed_pins     = pins;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_pins.size() != 0);
    endtask

    task automatic write_auto_enable(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        auto_en = value;
        cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one command, then keep the sequencer fed until it is idle again
    task automatic run_command(cmd_row_t row);
        int unsigned polls;
        int unsigned fill;
        logic        sdi;
        logic        cv;
        polls = 0;
        fill  = 0;
        if (row.cmd_valid && row.op != OP_UNUSED)
            commands_sent++;
        send_item(row.cmd_valid, row.op, row.addr, row.wdata, 1'($urandom_range(0, 1)),
                  row.typed, row.first_pins);
        while (seq_phase != SEQ_IDLE)
        begin
            if (row.cfg_mid && fill == 5)
            begin
                // flip the register mid-command; only the next command may see it
                drain_results();
                write_auto_enable(!auto_en);
            end
            if (seq_phase == SEQ_POLL)
            begin
                sdi = (polls >= row.poll_wait);
                polls++;
            end
            else if (seq_phase == SEQ_RECV && row.rx_mode != RX_RANDOM)
                sdi = (row.rx_mode == RX_ONES);
            else
                sdi = 1'($urandom_range(0, 1));
            cv = row.busy_cmd && ($urandom_range(0, 2) == 0);
            send_item(cv, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), sdi,
                      1'b0, NO_PINS);
            fill++;
        end
    endtask

    function automatic cmd_row_t random_row();
        cmd_row_t row;
        row            = '0;
        row.cmd_valid  = ($urandom_range(0, 9) != 0);
        row.op         = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        row.addr       = 8'($urandom);
        row.wdata      = 8'($urandom);
        row.rx_mode    = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 1)) : RX_RANDOM;
        row.poll_wait  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 60))
                                                     : 8'($urandom_range(0, 4));
        row.busy_cmd   = ($urandom_range(0, 3) == 0);
        row.cfg_mid    = ($urandom_range(0, 19) == 0);
        return row;
    endfunction

    task automatic random_phase(logic auto_setting);
        int unsigned stop_at;
        drain_results();
        write_auto_enable(auto_setting);
        stop_at = items_taken + ITEMS_PER_PHASE;
        while (items_taken < stop_at)
            run_command(random_row());
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        item_valid     = 1'b0;
        command_valid  = 1'b0;
        opcode         = OP_READ;
        address        = '0;
        write_data     = '0;
        serial_data_in = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct  = 33;
        recv_stall_pct = 49;
        for (int i = 0; i < N_DIRECTED; i++)
            run_command(DIRECTED_ROWS[i]);
        random_phase(1'b0);

        send_idle_pct  = 49;
        recv_stall_pct = 33;
        random_phase(1'b1);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(1'b0);
        random_phase(1'b1);

        repeat (10) @(posedge clk);
        if (pending_pins.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pins.size()));

        $display("ran %0d commands over %0d bit periods, %0d register writes",
                 commands_sent, items_taken, cfg_writes);
        $display("checked %0d result items, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("tb_microwire_eeprom_master passed");
        else
            $display("tb_microwire_eeprom_master failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/mwe_pkg.sv
hdl/mwe_front.sv
hdl/mwe_queue.sv
hdl/mwe_seq.sv
hdl/microwire_eeprom_master.sv
sim/tb_microwire_eeprom_master.sv
